// ===== rtl/core/sipq_pkg.sv =====
// ----------------------------------------------------------------------------
// sipq_pkg
// Types and constants of the sorted-insert priority queue.
// ----------------------------------------------------------------------------
package sipq_pkg;

    localparam int HOURS_W   = 5;
    localparam int MINUTES_W = 6;
    localparam int TAG_W     = 8;
    localparam int STATUS_W  = 2;
    localparam int OCC_W     = 4;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    typedef struct packed {
        logic [HOURS_W-1:0]   hours;
        logic [MINUTES_W-1:0] minutes;
        logic [TAG_W-1:0]     tag;
    } t_entry;

endpackage

// ===== rtl/core/sipq_if.sv =====
// ----------------------------------------------------------------------------
// sipq_if
// Valid/ready channels of the queue: request in, response out.
// ----------------------------------------------------------------------------
interface sipq_req_if;
    logic                                valid;
    logic                                ready;
    logic                                cmd;
    logic [sipq_pkg::HOURS_W-1:0]        key_hours;
    logic [sipq_pkg::MINUTES_W-1:0]      key_minutes;
    logic [sipq_pkg::TAG_W-1:0]          tag;

    modport source (output valid, cmd, key_hours, key_minutes, tag, input ready);
    modport sink   (input valid, cmd, key_hours, key_minutes, tag, output ready);
endinterface

interface sipq_rsp_if;
    logic                                valid;
    logic                                ready;
    logic [sipq_pkg::STATUS_W-1:0]       status;
    logic [sipq_pkg::HOURS_W-1:0]        out_hours;
    logic [sipq_pkg::MINUTES_W-1:0]      out_minutes;
    logic [sipq_pkg::TAG_W-1:0]          out_tag;
    logic [sipq_pkg::OCC_W-1:0]          occupancy;

    modport source (output valid, status, out_hours, out_minutes, out_tag, occupancy,
                    input ready);
    modport sink   (input valid, status, out_hours, out_minutes, out_tag, occupancy,
                    output ready);
endinterface

// ===== rtl/core/sorted_insert_priority_queue.sv =====
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue
// Bounded priority queue ordered by (hours, minutes); equal keys leave in
// arrival order. Entries sit in a ring in one synchronous RAM.
// ----------------------------------------------------------------------------
//  channel | dir | modport | payload
//  i_req   | in  | sink    | cmd, key_hours, key_minutes, tag
//  o_rsp   | out | source  | status, out_hours, out_minutes, out_tag, occupancy
//
//  One request at a time. A refused push or pop goes straight to the result state.
//  Pop: RAM read of the head, then the ring pointer advances.
//  Push: entries are compared walking back from the tail (S_PCMP),
//  one RAM read and one write per cycle; S_PNEW writes the new entry as head.
//  A result waiting in the output register does not block the next transfer.
//  Reset clears count, head pointer and handshake state; RAM is not cleared.
// ----------------------------------------------------------------------------
module sorted_insert_priority_queue #(
    parameter int CAPACITY = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    sipq_req_if.sink        i_req,
    sipq_rsp_if.source      o_rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [AW:0]   CAP_W   = (AW+1)'(CAPACITY);
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PCMP   = 3'd1;
    localparam logic [2:0] S_PNEW   = 3'd2;
    localparam logic [2:0] S_POPRD  = 3'd3;
    localparam logic [2:0] S_RESULT = 3'd4;

    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] base,
                                             input logic [AW-1:0] ofs);
        logic [AW:0] sum;
        sum = {1'b0, base} + {1'b0, ofs};
        if (sum >= CAP_W) begin
            sum = sum - CAP_W;
        end
        return sum[AW-1:0];
    endfunction

    sipq_pkg::t_entry r_mem [CAPACITY];
    sipq_pkg::t_entry r_rd_data;

    logic [2:0]                      r_state, n_state;
    logic [CW-1:0]                   r_count, n_count;
    logic [AW-1:0]                   r_head, n_head;
    logic [AW-1:0]                   r_j, n_j;
    sipq_pkg::t_entry                r_new, n_new;
    logic [sipq_pkg::STATUS_W-1:0]   r_res_status, n_res_status;
    sipq_pkg::t_entry                r_res_entry, n_res_entry;
    logic                            r_out_valid, n_out_valid;
    logic [sipq_pkg::STATUS_W-1:0]   r_out_status, n_out_status;
    sipq_pkg::t_entry                r_out_entry, n_out_entry;
    logic [sipq_pkg::OCC_W-1:0]      r_out_occ, n_out_occ;

    logic                            rd_en, wr_en;
    logic [AW-1:0]                   rd_addr, wr_addr;
    sipq_pkg::t_entry                wr_data;
    logic                            w_in_xfer, w_out_xfer, w_later;
    logic [CW-1:0]                   w_cnt_m1;
    logic [CW+3:0]                   w_cnt_ext;
    sipq_pkg::t_entry                w_in_entry;

    assign w_in_xfer  = i_req.valid && i_req.ready;
    assign w_out_xfer = r_out_valid && o_rsp.ready;
    assign w_cnt_m1   = r_count - CW'(1);
    assign w_cnt_ext  = {4'd0, r_count};
    assign w_later    = {r_rd_data.hours, r_rd_data.minutes} > {r_new.hours, r_new.minutes};
    assign w_in_entry = '{hours: i_req.key_hours, minutes: i_req.key_minutes,
                          tag: i_req.tag};

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_head       = r_head;
        n_j          = r_j;
        n_new        = r_new;
        n_res_status = r_res_status;
        n_res_entry  = r_res_entry;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_entry  = r_out_entry;
        n_out_occ    = r_out_occ;
        rd_en        = 1'b0;
        rd_addr      = r_head;
        wr_en        = 1'b0;
        wr_addr      = r_head;
        wr_data      = r_new;

        if (w_out_xfer) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_xfer) begin
                    n_new       = w_in_entry;
                    n_res_entry = '0;
                    if (i_req.cmd == sipq_pkg::CMD_PUSH) begin
                        if (r_count >= CAP_CNT) begin
                            n_res_status = sipq_pkg::ST_FULL;
                            n_state      = S_RESULT;
                        end else if (r_count == '0) begin
                            wr_en        = 1'b1;
                            wr_addr      = r_head;
                            wr_data      = w_in_entry;
                            n_count      = r_count + CW'(1);
                            n_res_status = sipq_pkg::ST_DONE;
                            n_state      = S_RESULT;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = f_phys(r_head, w_cnt_m1[AW-1:0]);
                            n_j     = w_cnt_m1[AW-1:0];
                            n_state = S_PCMP;
                        end
                    end else begin
                        if (r_count == '0 || r_count > CAP_CNT) begin
                            n_res_status = sipq_pkg::ST_EMPTY;
                            n_state      = S_RESULT;
                        end else begin
                            rd_en   = 1'b1;
                            rd_addr = r_head;
                            n_state = S_POPRD;
                        end
                    end
                end
            end
            S_PCMP: begin
                wr_en   = 1'b1;
                wr_addr = f_phys(r_head, r_j + AW'(1));
                if (w_later) begin
                    wr_data = r_rd_data;
                    if (r_j == '0) begin
                        n_state = S_PNEW;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = f_phys(r_head, r_j - AW'(1));
                        n_j     = r_j - AW'(1);
                    end
                end else begin
                    wr_data      = r_new;
                    n_count      = r_count + CW'(1);
                    n_res_status = sipq_pkg::ST_DONE;
                    n_state      = S_RESULT;
                end
            end
            S_PNEW: begin
                wr_en        = 1'b1;
                wr_addr      = r_head;
                wr_data      = r_new;
                n_count      = r_count + CW'(1);
                n_res_status = sipq_pkg::ST_DONE;
                n_state      = S_RESULT;
            end
            S_POPRD: begin
                n_res_entry  = r_rd_data;
                n_res_status = sipq_pkg::ST_DONE;
                n_head       = f_phys(r_head, AW'(1));
                n_count      = r_count - CW'(1);
                n_state      = S_RESULT;
            end
            S_RESULT: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_res_status;
                    n_out_entry  = r_res_entry;
                    n_out_occ    = w_cnt_ext[3:0];
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // entry RAM: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_head      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_head      <= n_head;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_j          <= n_j;
        r_new        <= n_new;
        r_res_status <= n_res_status;
        r_res_entry  <= n_res_entry;
        r_out_status <= n_out_status;
        r_out_entry  <= n_out_entry;
        r_out_occ    <= n_out_occ;
    end

    assign i_req.ready       = (r_state == S_IDLE);
    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.out_hours   = r_out_entry.hours;
    assign o_rsp.out_minutes = r_out_entry.minutes;
    assign o_rsp.out_tag     = r_out_entry.tag;
    assign o_rsp.occupancy   = r_out_occ;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP_CNT)
        else $error("entry count beyond capacity");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_head} < CAP_W)
        else $error("head pointer outside ring");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_xfer && i_req.cmd == sipq_pkg::CMD_POP && r_count == '0)
        |=> (r_state == S_RESULT && r_res_status == sipq_pkg::ST_EMPTY
             && $stable(r_count)))
        else $error("empty pop not refused");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_status != sipq_pkg::ST_DONE) |-> (r_out_entry == '0))
        else $error("refused transfer carries data");

endmodule

// ===== test/sorted_insert_priority_queue_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_insert_priority_queue_tb
// Self-checking bench for the sorted-insert priority queue. A scoreboard keeps
// its own sorted copy of the queue, predicts the response of every accepted
// request and checks each response transfer against the oldest prediction.
// The stimulus covers refused pushes and pops, equal keys, out-of-range keys
// and random fill/drain traffic with idling and a long receiver hold-off.
// ----------------------------------------------------------------------------

typedef struct packed {
    logic [sipq_pkg::STATUS_W-1:0]  status;
    logic [sipq_pkg::HOURS_W-1:0]   hours;
    logic [sipq_pkg::MINUTES_W-1:0] minutes;
    logic [sipq_pkg::TAG_W-1:0]     tag;
    logic [sipq_pkg::OCC_W-1:0]     occupancy;
} t_response;

class sipq_scoreboard;
    int                capacity;
    sipq_pkg::t_entry  held_entries[$];
    t_response         expected_responses[$];
    int                mismatches;

    function new(int cap);
        capacity   = cap;
        mismatches = 0;
    endfunction

    task report_mismatch(string what);
        $display("MISMATCH at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    function int pending();
        return expected_responses.size();
    endfunction

    function int fill();
        return held_entries.size();
    endfunction

    function void note_request(logic cmd, sipq_pkg::t_entry entry);
        t_response rsp;
        int        slot;
        rsp = '0;
        if (cmd == sipq_pkg::CMD_PUSH) begin
            if (held_entries.size() >= capacity) begin
                rsp.status = sipq_pkg::ST_FULL;
            end else begin
                slot = held_entries.size();
                for (int i = 0; i < held_entries.size(); i++) begin
                    if ({held_entries[i].hours, held_entries[i].minutes} >
                        {entry.hours, entry.minutes}) begin
                        slot = i;
                        break;
                    end
                end
                held_entries.insert(slot, entry);
                rsp.status = sipq_pkg::ST_DONE;
            end
        end else begin
            if (held_entries.size() == 0) begin
                rsp.status = sipq_pkg::ST_EMPTY;
            end else begin
                rsp.status  = sipq_pkg::ST_DONE;
                rsp.hours   = held_entries[0].hours;
                rsp.minutes = held_entries[0].minutes;
                rsp.tag     = held_entries[0].tag;
                void'(held_entries.pop_front());
            end
        end
        rsp.occupancy = sipq_pkg::OCC_W'(held_entries.size());
        expected_responses.insert(expected_responses.size(), rsp);
    endfunction

    task check_response(t_response got);
        t_response want;
        if (expected_responses.size() == 0) begin
            report_mismatch($sformatf("unexpected response st=%0d h=%0d m=%0d t=%0d occ=%0d",
                got.status, got.hours, got.minutes, got.tag, got.occupancy));
        end else begin
            want = expected_responses.pop_front();
            if (got.status !== want.status || got.hours !== want.hours ||
                got.minutes !== want.minutes || got.tag !== want.tag ||
                got.occupancy !== want.occupancy) begin
                report_mismatch($sformatf(
                    "st %0d/%0d h %0d/%0d m %0d/%0d t %0d/%0d occ %0d/%0d (got/exp)",
                    got.status, want.status, got.hours, want.hours,
                    got.minutes, want.minutes, got.tag, want.tag,
                    got.occupancy, want.occupancy));
            end
        end
    endtask
endclass

module sorted_insert_priority_queue_tb;

    localparam int CAPACITY = 8;

    logic i_clk;
    logic i_rst_n;

    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off_start;

    sipq_scoreboard board;

    sipq_req_if req_if ();
    sipq_rsp_if rsp_if ();

    sorted_insert_priority_queue #(
        .CAPACITY (CAPACITY)
    ) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // receiver: random ready, long hold-off on request, checks every transfer
    initial begin
        int        stall_left;
        t_response got;
        stall_left = 0;
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
                got.status    = rsp_if.status;
                got.hours     = rsp_if.out_hours;
                got.minutes   = rsp_if.out_minutes;
                got.tag       = rsp_if.out_tag;
                got.occupancy = rsp_if.occupancy;
                board.check_response(got);
            end
            if (hold_off_start) begin
                hold_off_start = 1'b0;
                stall_left     = 400;
            end
            if (stall_left > 0) begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    task automatic send_request(input logic cmd,
                                input logic [sipq_pkg::HOURS_W-1:0] hrs,
                                input logic [sipq_pkg::MINUTES_W-1:0] mins,
                                input logic [sipq_pkg::TAG_W-1:0] tg);
        sipq_pkg::t_entry entry;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid       <= 1'b1;
        req_if.cmd         <= cmd;
        req_if.key_hours   <= hrs;
        req_if.key_minutes <= mins;
        req_if.tag         <= tg;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        entry.hours   = hrs;
        entry.minutes = mins;
        entry.tag     = tg;
        board.note_request(cmd, entry);
    endtask

    // narrow keys give plenty of ties, wide keys reach past the legal range
    task automatic send_random(input logic cmd);
        logic [sipq_pkg::HOURS_W-1:0]   hrs;
        logic [sipq_pkg::MINUTES_W-1:0] mins;
        logic [sipq_pkg::TAG_W-1:0]     tg;
        if ($urandom_range(0, 1) == 0) begin
            hrs  = sipq_pkg::HOURS_W'($urandom_range(0, 3));
            mins = sipq_pkg::MINUTES_W'($urandom_range(0, 3));
        end else begin
            hrs  = sipq_pkg::HOURS_W'($urandom_range(0, (1 << sipq_pkg::HOURS_W) - 1));
            mins = sipq_pkg::MINUTES_W'($urandom_range(0, (1 << sipq_pkg::MINUTES_W) - 1));
        end
        tg = sipq_pkg::TAG_W'($urandom_range(0, (1 << sipq_pkg::TAG_W) - 1));
        send_request(cmd, hrs, mins, tg);
    endtask

    task automatic run_random(input int count);
        int push_pct;
        push_pct = 50;
        for (int n = 0; n < count; n++) begin
            if (n % 16 == 0) begin
                case ($urandom_range(0, 2))
                    0: push_pct = 80;
                    1: push_pct = 20;
                    default: push_pct = 50;
                endcase
            end
            send_random(($urandom_range(0, 99) < push_pct) ?
                        sipq_pkg::CMD_PUSH : sipq_pkg::CMD_POP);
        end
    endtask

    task automatic run_directed();
        send_request(sipq_pkg::CMD_POP, '0, '0, '0);
        send_request(sipq_pkg::CMD_PUSH, 5'd12, 6'd30, 8'hA1);
        send_request(sipq_pkg::CMD_PUSH, 5'd12, 6'd30, 8'hA2);
        send_request(sipq_pkg::CMD_PUSH, 5'd0, 6'd0, 8'h00);
        send_request(sipq_pkg::CMD_PUSH, 5'd31, 6'd63, 8'hFF);
        send_request(sipq_pkg::CMD_PUSH, 5'd24, 6'd60, 8'h55);
        send_request(sipq_pkg::CMD_PUSH, 5'd12, 6'd29, 8'h10);
        send_request(sipq_pkg::CMD_PUSH, 5'd12, 6'd31, 8'h20);
        send_request(sipq_pkg::CMD_PUSH, 5'd12, 6'd30, 8'hA3);
        send_request(sipq_pkg::CMD_PUSH, 5'd1, 6'd1, 8'h77);
        for (int i = 0; i < CAPACITY + 1; i++) begin
            send_request(sipq_pkg::CMD_POP, '1, '1, '1);
        end
        send_request(sipq_pkg::CMD_PUSH, 5'd31, 6'd0, 8'hC3);
        send_request(sipq_pkg::CMD_PUSH, 5'd0, 6'd63, 8'h3C);
        send_request(sipq_pkg::CMD_POP, '0, '0, '0);
        send_request(sipq_pkg::CMD_POP, '0, '0, '0);
    endtask

    initial begin
        int drain_cycles;
        board          = new(CAPACITY);
        send_idle_pct  = 8;
        recv_idle_pct  = 56;
        hold_off_start = 1'b0;
        i_rst_n            <= 1'b0;
        req_if.valid       <= 1'b0;
        req_if.cmd         <= sipq_pkg::CMD_PUSH;
        req_if.key_hours   <= '0;
        req_if.key_minutes <= '0;
        req_if.tag         <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        run_directed();
        run_random(210);

        send_idle_pct = 56;
        recv_idle_pct = 8;
        run_random(210);

        send_idle_pct  = 0;
        recv_idle_pct  = 0;
        hold_off_start = 1'b1;
        run_random(210);

        req_if.valid <= 1'b0;
        drain_cycles = 0;
        while (board.pending() != 0 && drain_cycles < 5000) begin
            @(posedge i_clk);
            drain_cycles++;
        end
        repeat (16) @(posedge i_clk);
        if (board.pending() != 0) begin
            board.report_mismatch($sformatf("%0d responses never arrived", board.pending()));
        end

        if (board.mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
